@@ src/concentric_disk_mapping_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Concentric disk mapping assertion macros
// Shared concurrent assertion forms with reset gating.
// ----------------------------------------------------------------------------
`ifndef CONCENTRIC_DISK_MAPPING_UNIT_MACROS_SVH
`define CONCENTRIC_DISK_MAPPING_UNIT_MACROS_SVH

// Same-cycle implication, gated off while reset is asserted.
`define CDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cdm assertion failed");

// Next-cycle implication, gated off while reset is asserted.
`define CDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cdm assertion failed");

`endif

@@ src/cdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Concentric disk mapping package
// Stage record, constants and per-stage datapath functions.
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned QUO_W        = 30;
  localparam int unsigned REM_W        = 46;
  localparam int unsigned DIV_BITS     = 2;
  localparam int unsigned DIV_STAGES   = QUO_W / DIV_BITS;
  localparam int unsigned VEC_W        = 34;
  localparam int unsigned ANG_W        = 32;

  localparam logic [29:0] PI_OVER_4_Q30   = 30'd843314857;
  localparam logic [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;

  localparam logic [31:0] ATAN_Q30 [0:ATAN_ENTRIES-1] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  typedef enum logic [1:0] {
    REGION_1 = 2'd0,
    REGION_2 = 2'd1,
    REGION_3 = 2'd2,
    REGION_4 = 2'd3
  } region_e;

  // Everything one sample carries down the pipeline.
  typedef struct packed {
    region_e                   region;
    logic                      zero;
    logic                      neg;
    logic [15:0]               r;
    logic [15:0]               an;
    logic [15:0]               ad;
    logic [REM_W-1:0]          rem;
    logic [QUO_W-1:0]          quo;
    logic signed [VEC_W-1:0]   x;
    logic signed [VEC_W-1:0]   y;
    logic signed [ANG_W-1:0]   z;
  } stage_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  // Two restoring division steps, the upper one at bit position hi.
  function automatic stage_t div_step(input stage_t s, input int unsigned hi);
    stage_t           o;
    logic [REM_W-1:0] sub;
    o = s;
    for (int k = 0; k < DIV_BITS; k++) begin
      sub = REM_W'(s.ad) << (hi - k);
      if (o.rem >= sub) begin
        o.rem         = o.rem - sub;
        o.quo[hi - k] = 1'b1;
      end
    end
    return o;
  endfunction

  // One rotation-mode CORDIC micro-rotation with floor shifts.
  function automatic stage_t rot_step(input stage_t s, input int unsigned idx);
    stage_t o;
    o = s;
    if (!s.z[ANG_W-1]) begin
      o.x = s.x - (s.y >>> idx);
      o.y = s.y + (s.x >>> idx);
      o.z = s.z - signed'(ATAN_Q30[idx]);
    end else begin
      o.x = s.x + (s.y >>> idx);
      o.y = s.y - (s.x >>> idx);
      o.z = s.z + signed'(ATAN_Q30[idx]);
    end
    return o;
  endfunction

  // Round half up from Q4.30 to Q1.15 and saturate.
  function automatic logic [15:0] to_q15(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W:0] t;
    t = (VEC_W+1)'(v) + (VEC_W+1)'(16384);
    t = t >>> 15;
    if (t > (VEC_W+1)'(32767)) begin
      to_q15 = 16'h7fff;
    end else if (t < -(VEC_W+1)'(32768)) begin
      to_q15 = 16'h8000;
    end else begin
      to_q15 = t[15:0];
    end
  endfunction

endpackage

@@ src/cdm_if.sv @@
// ----------------------------------------------------------------------------
// Concentric disk mapping channels
// Sample channel in, disk point channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdm_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] square_u;
  logic [15:0] square_v;

  modport source (output valid, output square_u, output square_v, input ready);
  modport sink   (input valid, input square_u, input square_v, output ready);
endinterface

interface cdm_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] disk_x;
  logic signed [15:0] disk_y;

  modport source (output valid, output disk_x, output disk_y, input ready);
  modport sink   (input valid, input disk_x, input disk_y, output ready);
endinterface

@@ src/cdm_stage_reg.sv @@
// ----------------------------------------------------------------------------
// Concentric disk mapping stage register
// One pipeline register with its valid bit; a bubble is filled even while
// the stage below stalls.
// ----------------------------------------------------------------------------
module cdm_stage_reg
  import cdm_pkg::*;
#(
  parameter type T = stage_t
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  T     data_q;

  // The stage takes a beat when empty or when its beat moves on.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/concentric_disk_mapping_unit.sv @@
// ----------------------------------------------------------------------------
// Concentric disk mapping unit
// Maps a square sample pair to a point on the unit disk, pipelined.
// ----------------------------------------------------------------------------
// Usage: a sample beat (square_u, square_v, unsigned Q0.16) enters on
// sample_i; one disk point beat (disk_x, disk_y, signed Q1.15) leaves on
// point_o for each sample, in order.
// The pipeline has one input stage, one multiply stage, fifteen radix-4
// divider stages for the angle ratio, one sign stage, one stage per CORDIC
// micro-rotation and one output stage that swaps into the pie region and
// rounds. Throughput is one beat per cycle while the receiver does not
// stall; every stage has its own valid bit.
// When the receiver stalls, the output stage holds its beat and upstream
// stages keep filling empty slots, so the input stalls only once the whole
// pipeline is full. Nothing is lost or repeated.
// Reset clears all valid bits; the pipeline then holds no beats.
// ----------------------------------------------------------------------------
`include "concentric_disk_mapping_unit_macros.svh"

module concentric_disk_mapping_unit
  import cdm_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdm_sample_if.sink  sample_i,
  cdm_point_if.source point_o
);

  localparam int unsigned NROT  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int unsigned S_MUL = 1;
  localparam int unsigned S_DIV = 2;
  localparam int unsigned S_TH  = S_DIV + DIV_STAGES;
  localparam int unsigned S_ROT = S_TH + 1;
  localparam int unsigned S_OUT = S_ROT + NROT;
  localparam int unsigned NSTG  = S_OUT + 1;

  stage_t stg_d [NSTG];
  stage_t stg_q [NSTG];
  logic   vld   [NSTG];
  logic   rdy   [NSTG];

  // Input stage: recenter and pick the pie region.
  always_comb begin
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [16:0] sum;
    logic signed [15:0] num;
    logic signed [15:0] den;
    logic               pos;
    a   = signed'({~sample_i.square_u[15], sample_i.square_u[14:0]});
    b   = signed'({~sample_i.square_v[15], sample_i.square_v[14:0]});
    sum = 17'(a) + 17'(b);
    pos = !sum[16] && (sum != 17'sd0);
    stg_d[0] = '0;
    if (pos && (a > b)) begin
      stg_d[0].region = REGION_1;
      stg_d[0].r      = 16'(a);
      num = b;
      den = a;
    end else if (pos) begin
      stg_d[0].region = REGION_2;
      stg_d[0].r      = 16'(b);
      num = a;
      den = b;
    end else if (a < b) begin
      stg_d[0].region = REGION_3;
      stg_d[0].r      = abs16(a);
      num = b;
      den = a;
    end else begin
      stg_d[0].region = REGION_4;
      stg_d[0].r      = abs16(b);
      num = a;
      den = b;
    end
    stg_d[0].an   = abs16(num);
    stg_d[0].ad   = abs16(den);
    stg_d[0].neg  = num[15] != den[15];
    stg_d[0].zero = den == 16'sd0;
  end

  // Multiply stage: dividend of the angle ratio and the gain-scaled radius.
  always_comb begin
    logic [47:0] prod;
    stg_d[S_MUL]     = stg_q[S_MUL-1];
    stg_d[S_MUL].rem = REM_W'(stg_q[S_MUL-1].an) * REM_W'(PI_OVER_4_Q30)
                     + REM_W'(stg_q[S_MUL-1].ad >> 1);
    stg_d[S_MUL].quo = '0;
    prod             = 48'(stg_q[S_MUL-1].r) * 48'(CORDIC_GAIN_Q32);
    prod             = (prod + 48'h10000) >> 17;
    stg_d[S_MUL].x   = signed'(VEC_W'(prod));
    stg_d[S_MUL].y   = '0;
  end

  // Divider stages: two quotient bits each, most significant first.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    always_comb begin
      stg_d[S_DIV+k] = div_step(stg_q[S_DIV+k-1], QUO_W - 1 - k * DIV_BITS);
    end
  end

  // Sign stage: the angle takes the sign of the ratio.
  always_comb begin
    logic signed [ANG_W-1:0] mag;
    mag            = signed'(ANG_W'(stg_q[S_TH-1].quo));
    stg_d[S_TH]    = stg_q[S_TH-1];
    stg_d[S_TH].z  = stg_q[S_TH-1].neg ? -mag : mag;
  end

  // CORDIC stages: one micro-rotation each.
  for (genvar i = 0; i < NROT; i++) begin : g_rot
    always_comb begin
      stg_d[S_ROT+i] = rot_step(stg_q[S_ROT+i-1], i);
    end
  end

  // Output stage: move into the pie region, round and saturate.
  always_comb begin
    logic signed [VEC_W-1:0] cx;
    logic signed [VEC_W-1:0] cy;
    case (stg_q[S_OUT-1].region)
      REGION_1: begin
        cx = stg_q[S_OUT-1].x;
        cy = stg_q[S_OUT-1].y;
      end
      REGION_2: begin
        cx = stg_q[S_OUT-1].y;
        cy = stg_q[S_OUT-1].x;
      end
      REGION_3: begin
        cx = -stg_q[S_OUT-1].x;
        cy = -stg_q[S_OUT-1].y;
      end
      default: begin
        cx = -stg_q[S_OUT-1].y;
        cy = -stg_q[S_OUT-1].x;
      end
    endcase
    stg_d[S_OUT] = stg_q[S_OUT-1];
    if (stg_q[S_OUT-1].zero) begin
      stg_d[S_OUT].x = '0;
      stg_d[S_OUT].y = '0;
    end else begin
      stg_d[S_OUT].x = VEC_W'(signed'(to_q15(cx)));
      stg_d[S_OUT].y = VEC_W'(signed'(to_q15(cy)));
    end
  end

  // Stage registers with their valid bits.
  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic vin;
    logic rin;
    if (s == 0) begin : g_first
      assign vin            = sample_i.valid;
      assign sample_i.ready = rdy[0];
    end else begin : g_mid
      assign vin = vld[s-1];
    end
    if (s == NSTG - 1) begin : g_last
      assign rin = point_o.ready;
    end else begin : g_inner
      assign rin = rdy[s+1];
    end
    cdm_stage_reg #(
      .T(stage_t)
    ) u_reg (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vin),
      .ready_o (rdy[s]),
      .data_i  (stg_d[s]),
      .valid_o (vld[s]),
      .ready_i (rin),
      .data_o  (stg_q[s])
    );
  end

  assign point_o.valid  = vld[NSTG-1];
  assign point_o.disk_x = signed'(stg_q[NSTG-1].x[15:0]);
  assign point_o.disk_y = signed'(stg_q[NSTG-1].y[15:0]);

  // A taken output frees every stage, so the input must be open.
  `CDM_ASSERT_IMP(a_ready_chain, clk_i, rst_ni, point_o.ready, sample_i.ready)
  // The angle ratio never exceeds one, so the quotient stays within pi/4.
  `CDM_ASSERT_IMP(a_quo_bound, clk_i, rst_ni, vld[S_TH-1] && !stg_q[S_TH-1].zero,
                  stg_q[S_TH-1].quo <= PI_OVER_4_Q30)
  // In the first region the rotated vector stays in the right half plane.
  `CDM_ASSERT_IMP(a_region1_x, clk_i, rst_ni,
                  vld[S_OUT-1] && !stg_q[S_OUT-1].zero && stg_q[S_OUT-1].region == REGION_1,
                  !stg_q[S_OUT-1].x[VEC_W-1])
  // A stalled output beat stays in place.
  `CDM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, vld[NSTG-1] && !point_o.ready, vld[NSTG-1])

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Concentric disk mapping unit testbench
// Drives sample beats through the unit under several idle and stall phases,
// predicts every disk point in fixed point and compares beat by beat.
// ----------------------------------------------------------------------------
module tb;
  import cdm_pkg::*;

  localparam int unsigned STEPS       = 16;
  localparam int unsigned LATENCY     = 19 + STEPS;
  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned RANDOM_BEATS = 750;

  typedef struct {
    logic signed [15:0] disk_x;
    logic signed [15:0] disk_y;
  } disk_point_t;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;
  bit   timed_out;

  cdm_sample_if sample_ch ();
  cdm_point_if  point_ch ();

  concentric_disk_mapping_unit #(.CORDIC_STEPS(STEPS)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch.sink),
    .point_o  (point_ch.source)
  );

  // Print one mismatch line and count it.
  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Floor division by a power of two.
  function automatic longint floor_shr(input longint v, input int unsigned s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] round_q15(input longint v);
    longint q;
    q = floor_shr(v + 64'sd16384, 15);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  // Bit-exact prediction of one disk point.
  function automatic disk_point_t map_to_disk(input logic [15:0] u, input logic [15:0] v);
    longint      a, b, num, den, r, an, ad, mag, theta, x, y, dx, dy, cx, cy;
    region_e     region;
    disk_point_t p;
    a = longint'(u) - 32768;
    b = longint'(v) - 32768;
    if (a + b > 0) begin
      if (a > b) begin
        region = REGION_1; r = a; num = b; den = a;
      end else begin
        region = REGION_2; r = b; num = a; den = b;
      end
    end else begin
      if (a < b) begin
        region = REGION_3; r = -a; num = b; den = a;
      end else begin
        region = REGION_4; r = -b; num = a; den = b;
      end
    end
    // The origin maps to the centre with angle zero.
    if (den == 0) begin
      p.disk_x = 0;
      p.disk_y = 0;
      return p;
    end
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    mag = (an * longint'(PI_OVER_4_Q30) + ad / 2) / ad;
    theta = ((num < 0) != (den < 0)) ? -mag : mag;
    x = (r * longint'(CORDIC_GAIN_Q32) + (64'sd1 <<< 16)) >>> 17;
    y = 0;
    for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (theta >= 0) begin
        x -= dx; y += dy; theta -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; theta += longint'(ATAN_Q30[i]);
      end
    end
    case (region)
      REGION_1: begin cx = x;  cy = y;  end
      REGION_2: begin cx = y;  cy = x;  end
      REGION_3: begin cx = -x; cy = -y; end
      default:  begin cx = -y; cy = -x; end
    endcase
    p.disk_x = round_q15(cx);
    p.disk_y = round_q15(cy);
    return p;
  endfunction

  // Holds the disk points still owed by the unit, oldest first.
  class disk_scoreboard;
    disk_point_t pending_points[$];

    function void note_sample(input logic [15:0] u, input logic [15:0] v);
      pending_points.push_back(map_to_disk(u, v));
    endfunction

    task check_point(input logic signed [15:0] x, input logic signed [15:0] y);
      disk_point_t want;
      if (pending_points.size() == 0) begin
        report("unexpected beat disk_x", x, 0);
        return;
      end
      want = pending_points.pop_front();
      if (x !== want.disk_x) report("disk_x", x, want.disk_x);
      if (y !== want.disk_y) report("disk_y", y, want.disk_y);
    endtask
  endclass

  disk_scoreboard points_sb = new();

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: stall at random, check every accepted beat at the rising edge.
  always @(negedge clk_i) begin
    point_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && point_ch.valid && point_ch.ready)
      points_sb.check_point(point_ch.disk_x, point_ch.disk_y);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (point_ch.valid && point_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one sample beat, idling first at random, and wait for acceptance.
  // The valid line is left high so that beats can follow back to back.
  task automatic send_sample(input logic [15:0] u, input logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid    <= 1'b1;
    sample_ch.square_u <= u;
    sample_ch.square_v <= v;
    do @(posedge clk_i); while (!sample_ch.ready);
    points_sb.note_sample(u, v);
    @(negedge clk_i);
  endtask

  // Random pair biased toward region borders, the axes and the extremes.
  task automatic send_random();
    logic [15:0] u, v;
    u = 16'($urandom);
    v = 16'($urandom);
    case ($urandom_range(7))
      0: v = u;
      1: v = 16'(65536 - u);
      2: u = 16'h8000;
      3: v = 16'h8000;
      4: begin u = 16'($urandom_range(1) ? 0 : 65535); end
      default: ;
    endcase
    send_sample(u, v);
  endtask

  initial begin
    logic [15:0] edges[6] = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'h8001, 16'hffff};
    mismatches         = 0;
    quiet_cycles       = 0;
    timed_out          = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    rst_ni             = 1'b0;
    sample_ch.valid    = 1'b0;
    sample_ch.square_u = '0;
    sample_ch.square_v = '0;
    point_ch.ready     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: the origin, the corners, the diagonals and the axes.
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        send_sample(edges[i == 4 ? 5 : i], edges[j == 4 ? 5 : (j + 1) % 6]);

    // Random phases: free running, idle sender, stalled receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 32 : 0;
      recv_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 32 : 0;
      for (int n = 0; n < RANDOM_BEATS / 4; n++) send_random();
    end
    sample_ch.valid <= 1'b0;

    while (points_sb.pending_points.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+src
src/cdm_pkg.sv
src/cdm_if.sv
src/cdm_stage_reg.sv
src/concentric_disk_mapping_unit.sv
sim/tb.sv
